// ===== rtl/srsm_pkg.sv =====
// Shared types and constants for the slot ring state manager.
// Used by the controller, the datapath and the top level; no dependencies.
`timescale 1ns / 1ps

package srsm_pkg;

    localparam int MAX_SLOTS    = 64;
    localparam int SLOT_IDX_W   = 6;
    localparam int COUNT_W      = 7;
    localparam int SIZE_W       = 32;
    localparam int REQ_W        = 2;
    localparam int STATUS_W     = 2;
    localparam int PHASE_W      = 2;
    localparam int TDATA_W      = 40;
    localparam int REDUCE_STEPS = 6;
    localparam int STEP_W       = 3;

    localparam logic [REQ_W-1:0] REQ_CLAIM_WRITE = 2'd0;
    localparam logic [REQ_W-1:0] REQ_COMMIT      = 2'd1;
    localparam logic [REQ_W-1:0] REQ_CLAIM_READ  = 2'd2;
    localparam logic [REQ_W-1:0] REQ_RELEASE     = 2'd3;

    localparam logic [PHASE_W-1:0] PHASE_FREE    = 2'd0;
    localparam logic [PHASE_W-1:0] PHASE_WRITING = 2'd1;
    localparam logic [PHASE_W-1:0] PHASE_READY   = 2'd2;
    localparam logic [PHASE_W-1:0] PHASE_READING = 2'd3;

    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NONE  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd2;

    localparam logic [COUNT_W-1:0] SLOTS_RESET = 7'd64;

    typedef struct packed {
        logic accept;
        logic reduce_step;
        logic scan;
        logic pick;
        logic apply;
        logic load_out;
    } srsm_cmd_t;

    typedef struct packed {
        logic in_claim;
        logic in_need_reduce;
    } srsm_stat_t;

endpackage

// ===== rtl/srsm_ctrl.sv =====
// Controller state machine for the slot ring state manager.
// Sequences each request through the datapath; depends on srsm_pkg.
`timescale 1ns / 1ps

module srsm_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    output logic               m_tvalid,
    input  logic               m_tready,
    input  srsm_pkg::srsm_stat_t stat,
    output srsm_pkg::srsm_cmd_t  cmd
);
    import srsm_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_SCAN,
        ST_PICK,
        ST_APPLY,
        ST_DONE
    } state_t;

    state_t              state_reg, state_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic                out_valid_reg, out_valid_next;
    logic                out_free;

    assign out_free = !out_valid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;

    always_comb
    begin
        cmd             = '0;
        cmd.accept      = (state_reg == ST_IDLE) && s_tvalid;
        cmd.reduce_step = (state_reg == ST_REDUCE);
        cmd.scan        = (state_reg == ST_SCAN);
        cmd.pick        = (state_reg == ST_PICK);
        cmd.apply       = (state_reg == ST_APPLY);
        cmd.load_out    = (state_reg == ST_DONE) && out_free;
    end

    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        out_valid_next = out_valid_reg;
        if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE:
            begin
                step_next = '0;
                if (s_tvalid)
                begin
                    if (!stat.in_claim)
                    begin
                        state_next = ST_APPLY;
                    end
                    else if (stat.in_need_reduce)
                    begin
                        state_next = ST_REDUCE;
                    end
                    else
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_REDUCE:
            begin
                step_next = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(REDUCE_STEPS - 1))
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:  state_next = ST_PICK;
            ST_PICK:  state_next = ST_DONE;
            ST_APPLY: state_next = ST_DONE;
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== rtl/srsm_datapath.sv =====
// Datapath for the slot ring state manager: slot phases, length memory,
// hints, hint reduction, rotating search and result register. Uses srsm_pkg.
`timescale 1ns / 1ps

module srsm_datapath (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  srsm_pkg::srsm_cmd_t                  cmd,
    output srsm_pkg::srsm_stat_t                 stat,
    input  logic                                 cfg_wr_en,
    input  logic [srsm_pkg::COUNT_W-1:0]         cfg_wr_data,
    input  logic [srsm_pkg::REQ_W-1:0]           req_type,
    input  logic [srsm_pkg::SLOT_IDX_W-1:0]      slot_index,
    input  logic [srsm_pkg::SIZE_W-1:0]          payload_size,
    output logic [srsm_pkg::STATUS_W-1:0]        status,
    output logic [srsm_pkg::SLOT_IDX_W-1:0]      granted_slot,
    output logic [srsm_pkg::SIZE_W-1:0]          ready_size
);
    import srsm_pkg::*;

    logic [COUNT_W-1:0]    slots_in_use_reg;
    logic [PHASE_W-1:0]    phase_reg [MAX_SLOTS];
    logic [MAX_SLOTS-1:0]  len_valid_reg;
    logic [SIZE_W-1:0]     length_mem [MAX_SLOTS];
    logic [SLOT_IDX_W-1:0] write_hint_reg, read_hint_reg;

    logic [REQ_W-1:0]      req_reg;
    logic [SLOT_IDX_W-1:0] sel_reg;
    logic [SIZE_W-1:0]     size_reg;
    logic [COUNT_W-1:0]    n_reg;
    logic [SLOT_IDX_W-1:0] start_reg;
    logic [SLOT_IDX_W-1:0] div_reg;
    logic [COUNT_W-1:0]    rem_reg;
    logic [MAX_SLOTS-1:0]  hi_mask_reg, lo_mask_reg;

    logic [STATUS_W-1:0]   res_status_reg;
    logic [SLOT_IDX_W-1:0] res_granted_reg;
    logic                  res_read_reg;
    logic [SIZE_W-1:0]     rd_data_reg;
    logic                  rd_valid_reg;

    logic [STATUS_W-1:0]   out_status_reg;
    logic [SLOT_IDX_W-1:0] out_granted_reg;
    logic [SIZE_W-1:0]     out_size_reg;

    logic [COUNT_W-1:0]    n_now;
    logic [SLOT_IDX_W-1:0] hint_now;
    logic                  in_claim;
    logic [COUNT_W-1:0]    rem_shift, rem_sub;
    logic                  is_write_claim;
    logic [PHASE_W-1:0]    want_phase;
    logic                  found;
    logic [SLOT_IDX_W-1:0] pick_idx;
    logic [COUNT_W-1:0]    idx_plus;
    logic [SLOT_IDX_W-1:0] hint_after;
    logic                  sel_in_range;

    function automatic logic [SLOT_IDX_W-1:0] first_set(input logic [MAX_SLOTS-1:0] v);
        logic [SLOT_IDX_W-1:0] r;
        r = '0;
        for (int i = MAX_SLOTS - 1; i >= 0; i--)
        begin
            if (v[i])
            begin
                r = SLOT_IDX_W'(i);
            end
        end
        return r;
    endfunction

    // Active count saturates at the table size.
    assign n_now    = (slots_in_use_reg > COUNT_W'(MAX_SLOTS)) ? COUNT_W'(MAX_SLOTS)
                                                               : slots_in_use_reg;
    assign in_claim = (req_type == REQ_CLAIM_WRITE) || (req_type == REQ_CLAIM_READ);
    assign hint_now = (req_type == REQ_CLAIM_READ) ? read_hint_reg : write_hint_reg;

    assign stat.in_claim       = in_claim;
    assign stat.in_need_reduce = (n_now != '0) && ({1'b0, hint_now} >= n_now);

    // One restoring remainder step per cycle: start = hint mod active count.
    assign rem_shift = {rem_reg[COUNT_W-2:0], div_reg[SLOT_IDX_W-1]};
    assign rem_sub   = (rem_shift >= n_reg) ? (rem_shift - n_reg) : rem_shift;

    assign is_write_claim = (req_reg == REQ_CLAIM_WRITE);
    assign want_phase     = is_write_claim ? PHASE_FREE : PHASE_READY;
    assign found          = |lo_mask_reg;
    assign pick_idx       = (|hi_mask_reg) ? first_set(hi_mask_reg) : first_set(lo_mask_reg);
    assign idx_plus       = {1'b0, pick_idx} + COUNT_W'(1);
    assign hint_after     = (idx_plus == n_reg) ? '0 : idx_plus[SLOT_IDX_W-1:0];
    assign sel_in_range   = ({1'b0, sel_reg} < n_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slots_in_use_reg <= SLOTS_RESET;
        end
        else if (cfg_wr_en)
        begin
            slots_in_use_reg <= cfg_wr_data;
        end
    end

    // Request capture, reduction and search masks.
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            req_reg   <= req_type;
            sel_reg   <= slot_index;
            size_reg  <= payload_size;
            n_reg     <= n_now;
            start_reg <= hint_now;
            div_reg   <= hint_now;
            rem_reg   <= '0;
        end
        if (cmd.reduce_step)
        begin
            rem_reg   <= rem_sub;
            div_reg   <= {div_reg[SLOT_IDX_W-2:0], 1'b0};
            start_reg <= rem_sub[SLOT_IDX_W-1:0];
        end
        if (cmd.scan)
        begin
            for (int i = 0; i < MAX_SLOTS; i++)
            begin
                lo_mask_reg[i] <= (phase_reg[i] == want_phase) && (COUNT_W'(i) < n_reg);
                hi_mask_reg[i] <= (phase_reg[i] == want_phase) && (COUNT_W'(i) < n_reg)
                                  && (SLOT_IDX_W'(i) >= start_reg);
            end
        end
    end

    // Slot phases, length valid bits and hints.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_SLOTS; i++)
            begin
                phase_reg[i] <= PHASE_FREE;
            end
            len_valid_reg  <= '0;
            write_hint_reg <= '0;
            read_hint_reg  <= '0;
        end
        else
        begin
            if (cmd.pick && found)
            begin
                if (is_write_claim)
                begin
                    phase_reg[pick_idx] <= PHASE_WRITING;
                    write_hint_reg      <= hint_after;
                end
                else
                begin
                    phase_reg[pick_idx] <= PHASE_READING;
                    read_hint_reg       <= hint_after;
                end
            end
            if (cmd.apply && sel_in_range)
            begin
                if (req_reg == REQ_COMMIT)
                begin
                    phase_reg[sel_reg]     <= PHASE_READY;
                    len_valid_reg[sel_reg] <= 1'b1;
                end
                else
                begin
                    phase_reg[sel_reg] <= PHASE_FREE;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.apply && sel_in_range && (req_reg == REQ_COMMIT))
        begin
            length_mem[sel_reg] <= size_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.pick)
        begin
            rd_data_reg  <= length_mem[pick_idx];
            rd_valid_reg <= len_valid_reg[pick_idx];
        end
    end

    // Result and output register.
    always_ff @(posedge clk)
    begin
        if (cmd.pick)
        begin
            res_status_reg  <= found ? STATUS_OK : STATUS_NONE;
            res_granted_reg <= found ? pick_idx : '0;
            res_read_reg    <= found && !is_write_claim;
        end
        if (cmd.apply)
        begin
            res_status_reg  <= sel_in_range ? STATUS_OK : STATUS_RANGE;
            res_granted_reg <= sel_in_range ? sel_reg : '0;
            res_read_reg    <= 1'b0;
        end
        if (cmd.load_out)
        begin
            out_status_reg  <= res_status_reg;
            out_granted_reg <= res_granted_reg;
            out_size_reg    <= (res_read_reg && rd_valid_reg) ? rd_data_reg : '0;
        end
    end

    assign status       = out_status_reg;
    assign granted_slot = out_granted_reg;
    assign ready_size   = out_size_reg;

endmodule

// ===== rtl/slot_ring_state_manager_unit.sv =====
// Slot ring state manager, top level: a table of slots with claim states.
// Packs the stream words and joins srsm_ctrl and srsm_datapath; uses srsm_pkg.
//
// The slave stream takes one request word, the master stream returns exactly
// one result word per request, in order. A request is one of claim write,
// commit, claim read and release. cfg_wr_en/cfg_wr_data set the number of
// active slots; write it only while no request is in flight.
// One request is worked on at a time. Commit and release pass through accept,
// apply and output load; a claim passes through accept, mask build, priority
// pick and output load, plus a one-bit-per-cycle remainder reduction when
// its search hint lies at or beyond the active count (after that count was
// lowered). The slot phase flops are read by one registered search over all
// slots; sizes live in a 64-entry memory read per claim, used by read claims.
// Reset frees all slots, zeroes the stored sizes (through per-slot valid
// bits), clears both hints and sets the active count to 64; it needs no
// clearing pass. The result word sits in an output register: a new request
// is taken while it waits, but the next result is held back until the
// receiver takes the previous one with m_tready.
`timescale 1ns / 1ps

module slot_ring_state_manager_unit (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // req_type [1:0], slot_index [7:2], payload_size [39:8]
    input  logic [srsm_pkg::TDATA_W-1:0]       s_tdata,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // status [1:0], granted_slot [7:2], ready_size [39:8]
    output logic [srsm_pkg::TDATA_W-1:0]       m_tdata,
    input  logic                               cfg_wr_en,
    input  logic [srsm_pkg::COUNT_W-1:0]       cfg_wr_data
);
    import srsm_pkg::*;

    srsm_cmd_t             cmd;
    srsm_stat_t            stat;
    logic [STATUS_W-1:0]   status;
    logic [SLOT_IDX_W-1:0] granted_slot;
    logic [SIZE_W-1:0]     ready_size;

    srsm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    srsm_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .req_type     (s_tdata[1:0]),
        .slot_index   (s_tdata[7:2]),
        .payload_size (s_tdata[39:8]),
        .status       (status),
        .granted_slot (granted_slot),
        .ready_size   (ready_size)
    );

    assign m_tdata = {ready_size, granted_slot, status};

endmodule
